FILE: hw/rtl/assert_macros.svh
// Assertion macros for the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define FCR_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled while reset is low.
`define FCR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

FILE: hw/rtl/fcr_pkg.sv
// Types and constants of the FIR convolution reverb.
package fcr_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int TAP_W     = 24;
    localparam int TAP_IDX_W = 13;
    localparam int LEVEL_W   = 17;
    localparam int CNT_W     = 14;
    localparam int CFG_IDX_W = 2;

    localparam logic [LEVEL_W-1:0] Q16_ONE        = 17'd65536;
    localparam logic [LEVEL_W-1:0] MIX_RESET      = 17'd19661;
    localparam logic [LEVEL_W-1:0] WIDTH_RESET    = 17'd65536;
    localparam logic [CNT_W-1:0]   PREDELAY_RESET = 14'd240;
    localparam logic [CNT_W-1:0]   TAPS_RESET     = 14'd0;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7FFFFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 24'h800000;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TAP    = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIX      = 2'd0,
        CFG_WIDTH    = 2'd1,
        CFG_PREDELAY = 2'd2,
        CFG_TAPS     = 2'd3
    } fcr_cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_WRITE,
        ST_MAC,
        ST_DRAIN,
        ST_WET,
        ST_MIX1,
        ST_MIX2,
        ST_DONE
    } fcr_state_t;

    typedef struct packed {
        logic                        opcode;
        logic                        channel_id;
        logic signed [SAMPLE_W-1:0]  sample_in;
        logic [TAP_IDX_W-1:0]        tap_index;
        logic signed [TAP_W-1:0]     tap_value;
    } fcr_in_t;

    typedef struct packed {
        logic                        channel_out;
        logic signed [SAMPLE_W-1:0]  sample_out;
        logic                        clipped;
    } fcr_out_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] mix_level;
        logic [LEVEL_W-1:0] width_level;
        logic [CNT_W-1:0]   predelay_samples;
        logic [CNT_W-1:0]   tap_count;
    } fcr_cfg_t;

    typedef struct packed {
        logic load;
        logic scale;
        logic hist_write;
        logic mac_issue;
        logic wet;
        logic mix1;
        logic mix2;
        logic out_load;
    } fcr_cmd_t;

    typedef struct packed {
        logic taps_zero;
        logic mac_last;
        logic pipe_empty;
        logic out_busy;
    } fcr_status_t;

endpackage

FILE: hw/rtl/fir_convolution_reverb.sv
// Top level of the two-channel FIR convolution reverb with predelay.
//
// Input channel s_*: one beat is either a tap load (opcode 1, writes one impulse
// coefficient, no result) or a Q1.23 sample of channel 0 or 1 (opcode 0, one
// result beat on m_*). Config channel cfg_*: ready whenever out of reset, register
// index and data; write only while the block is idle.
// A tap load leaves the block idle and ready. A sample is written to the
// history, run through the taps, rounded and mixed, then loaded to the output
// register; with tap_count 0 it skips the taps and the mix. Its run time is
// set by the single multiply-accumulate unit, which reads one history and one
// tap entry a cycle. One sample is in flight at a time; s_ready is high only
// when idle and out of reset.
// Reset clears the configuration to its defaults, the ring positions and the
// per-channel fill counts; history entries not yet written read as zero, so no
// clearing pass is needed. Taps must be loaded before they are used.
// A finished result sits in the output register; if the receiver stalls, the
// next sample is still accepted and computed, and waits at its end until the
// output register frees up.
module fir_convolution_reverb #(
    parameter int MAX_TAPS     = 8192,
    parameter int MAX_PREDELAY = 16384
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  fcr_pkg::fcr_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output fcr_pkg::fcr_out_t              m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fcr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fcr_pkg::LEVEL_W-1:0]    cfg_data
);

    fcr_pkg::fcr_cfg_t    cfg;
    fcr_pkg::fcr_cmd_t    cmd;
    fcr_pkg::fcr_status_t status;

    fcr_cfg_regs #(
        .MAX_TAPS     (MAX_TAPS),
        .MAX_PREDELAY (MAX_PREDELAY)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fcr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_data.opcode),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    fcr_datapath #(
        .MAX_TAPS     (MAX_TAPS),
        .MAX_PREDELAY (MAX_PREDELAY)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cfg     (cfg),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: hw/rtl/fcr_cfg_regs.sv
// Configuration registers with range clamping on write.
module fcr_cfg_regs #(
    parameter int MAX_TAPS     = 8192,
    parameter int MAX_PREDELAY = 16384
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fcr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fcr_pkg::LEVEL_W-1:0]    cfg_data,
    output fcr_pkg::fcr_cfg_t              cfg
);

    fcr_pkg::fcr_cfg_t cfg_reg, cfg_next;

    function automatic logic [fcr_pkg::LEVEL_W-1:0] clamp_level(
        input logic [fcr_pkg::LEVEL_W-1:0] v
    );
        return (v > fcr_pkg::Q16_ONE) ? fcr_pkg::Q16_ONE : v;
    endfunction

    function automatic logic [fcr_pkg::CNT_W-1:0] clamp_pd(
        input logic [fcr_pkg::CNT_W-1:0] v
    );
        return (32'(v) > MAX_PREDELAY - 1) ? fcr_pkg::CNT_W'(MAX_PREDELAY - 1) : v;
    endfunction

    function automatic logic [fcr_pkg::CNT_W-1:0] clamp_taps(
        input logic [fcr_pkg::CNT_W-1:0] v
    );
        return (32'(v) > MAX_TAPS) ? fcr_pkg::CNT_W'(MAX_TAPS) : v;
    endfunction

    assign cfg_ready = aresetn;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                fcr_pkg::CFG_MIX:      cfg_next.mix_level   = clamp_level(cfg_data);
                fcr_pkg::CFG_WIDTH:    cfg_next.width_level = clamp_level(cfg_data);
                fcr_pkg::CFG_PREDELAY: begin
                    cfg_next.predelay_samples = clamp_pd(cfg_data[fcr_pkg::CNT_W-1:0]);
                end
                fcr_pkg::CFG_TAPS: begin
                    cfg_next.tap_count = clamp_taps(cfg_data[fcr_pkg::CNT_W-1:0]);
                end
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mix_level        <= fcr_pkg::MIX_RESET;
            cfg_reg.width_level      <= fcr_pkg::WIDTH_RESET;
            cfg_reg.predelay_samples <= clamp_pd(fcr_pkg::PREDELAY_RESET);
            cfg_reg.tap_count        <= fcr_pkg::TAPS_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hw/rtl/fcr_ctrl.sv
// Sequencing state machine of the reverb.
module fcr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_opcode,
    output logic                 s_ready,
    input  fcr_pkg::fcr_status_t status,
    output fcr_pkg::fcr_cmd_t    cmd
);

    fcr_pkg::fcr_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fcr_pkg::ST_IDLE: begin
                if (s_valid && s_opcode == fcr_pkg::OP_SAMPLE) state_next = fcr_pkg::ST_SCALE;
            end
            fcr_pkg::ST_SCALE: state_next = fcr_pkg::ST_WRITE;
            fcr_pkg::ST_WRITE: begin
                state_next = status.taps_zero ? fcr_pkg::ST_DONE : fcr_pkg::ST_MAC;
            end
            fcr_pkg::ST_MAC: begin
                if (status.mac_last) state_next = fcr_pkg::ST_DRAIN;
            end
            fcr_pkg::ST_DRAIN: begin
                if (status.pipe_empty) state_next = fcr_pkg::ST_WET;
            end
            fcr_pkg::ST_WET:  state_next = fcr_pkg::ST_MIX1;
            fcr_pkg::ST_MIX1: state_next = fcr_pkg::ST_MIX2;
            fcr_pkg::ST_MIX2: state_next = fcr_pkg::ST_DONE;
            fcr_pkg::ST_DONE: begin
                if (!status.out_busy) state_next = fcr_pkg::ST_IDLE;
            end
            default: state_next = fcr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd            = '0;
        s_ready        = 1'b0;
        case (state_reg)
            fcr_pkg::ST_IDLE: begin
                s_ready  = aresetn;
                cmd.load = s_valid && aresetn;
            end
            fcr_pkg::ST_SCALE: cmd.scale      = 1'b1;
            fcr_pkg::ST_WRITE: cmd.hist_write = 1'b1;
            fcr_pkg::ST_MAC:   cmd.mac_issue  = 1'b1;
            fcr_pkg::ST_WET:   cmd.wet        = 1'b1;
            fcr_pkg::ST_MIX1:  cmd.mix1       = 1'b1;
            fcr_pkg::ST_MIX2:  cmd.mix2       = 1'b1;
            fcr_pkg::ST_DONE:  cmd.out_load   = !status.out_busy;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fcr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/fcr_datapath.sv
// Datapath: history and tap memories, MAC pipeline, mixer, output register.
module fcr_datapath #(
    parameter int MAX_TAPS     = 8192,
    parameter int MAX_PREDELAY = 16384
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fcr_pkg::fcr_in_t     s_data,
    input  fcr_pkg::fcr_cfg_t    cfg,
    input  fcr_pkg::fcr_cmd_t    cmd,
    output fcr_pkg::fcr_status_t status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output fcr_pkg::fcr_out_t    m_data
);

    localparam int SW       = fcr_pkg::SAMPLE_W;
    localparam int HIST_LEN = MAX_TAPS + MAX_PREDELAY;
    localparam int HA_W     = $clog2(HIST_LEN);
    localparam int FILL_W   = $clog2(HIST_LEN + 1);
    localparam int TAP_AW   = $clog2(MAX_TAPS);
    localparam int SCL_W    = SW + 19;
    localparam int PROD_W   = SW + fcr_pkg::TAP_W;
    localparam int ACC_W    = PROD_W + $clog2(MAX_TAPS);
    localparam int WET_W    = ACC_W - 21;
    localparam int PDRY_W   = SW + 18;
    localparam int PWET_W   = WET_W + 18;
    localparam int SUM_W    = PWET_W + 1;

    localparam logic signed [SUM_W-1:0] RES_MAX = SUM_W'((64'd1 << (SW - 1)) - 64'd1);
    localparam logic signed [SUM_W-1:0] RES_MIN = -RES_MAX - 1;

    // item and memories
    fcr_pkg::fcr_in_t    item_reg;
    logic [fcr_pkg::TAP_W-1:0] tap_mem [MAX_TAPS];
    logic [SW-1:0]       hist_mem [2][HIST_LEN];

    logic [HA_W-1:0]     pos_reg [2];
    logic [FILL_W-1:0]   fill_reg [2];
    logic [HA_W-1:0]     rd_addr_reg;
    logic [TAP_AW-1:0]   k_reg;

    logic signed [SCL_W-1:0]  scl_prod_reg;
    logic signed [SW-1:0]     dry_reg;
    logic [SW-1:0]            hist_q_reg;
    logic [fcr_pkg::TAP_W-1:0] tap_q_reg;
    logic                     hvld_q_reg;
    logic                     s1_v_reg, s2_v_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [WET_W-1:0]  wet_reg;
    logic signed [PDRY_W-1:0] pdry_reg;
    logic signed [PWET_W-1:0] pwet_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     out_valid_reg;
    fcr_pkg::fcr_out_t        out_data_reg;

    // combinational values
    logic                     ch;
    logic                     tap_wr;
    logic signed [SCL_W-1:0]  scl_a, scl_b, scl_tmp, scl_rnd;
    logic                     apply_scale;
    logic signed [SW-1:0]     dry_val;
    logic [HA_W-1:0]          pos_cur, pos_nxt;
    logic [FILL_W-1:0]        fill_cur;
    logic [HA_W:0]            pos_ext, pd_ext, start_ext;
    logic                     hist_valid;
    logic signed [SW-1:0]     hist_op;
    logic signed [ACC_W-1:0]  wet_tmp, wet_sh;
    logic signed [PDRY_W-1:0] dry_op, inv_op;
    logic signed [PWET_W-1:0] wet_op, mix_op;
    logic signed [SUM_W-1:0]  sum_a, sum_b, rnd_tmp, rnd;
    fcr_pkg::fcr_out_t        out_next;

    assign ch     = item_reg.channel_id;
    assign tap_wr = cmd.load && s_data.opcode == fcr_pkg::OP_TAP
                    && 32'(s_data.tap_index) < MAX_TAPS;

    // width scaling of channel one
    assign scl_a       = SCL_W'($signed(item_reg.sample_in));
    assign scl_b       = $signed(SCL_W'({1'b0, cfg.width_level} + 18'd65536));
    assign apply_scale = ch && cfg.width_level != fcr_pkg::Q16_ONE;
    assign scl_tmp     = scl_prod_reg + SCL_W'(65536) - SCL_W'(scl_prod_reg[SCL_W-1]);
    assign scl_rnd     = scl_tmp >>> 17;
    assign dry_val     = apply_scale ? SW'(scl_rnd) : $signed(item_reg.sample_in);

    // history ring addressing
    assign pos_cur   = pos_reg[ch];
    assign fill_cur  = fill_reg[ch];
    assign pos_nxt   = (pos_cur == HA_W'(HIST_LEN - 1)) ? '0 : pos_cur + 1'b1;
    assign pos_ext   = {1'b0, pos_cur};
    assign pd_ext    = (HA_W + 1)'(cfg.predelay_samples);
    assign start_ext = (pos_ext >= pd_ext) ? pos_ext - pd_ext
                                           : pos_ext + (HA_W + 1)'(HIST_LEN) - pd_ext;
    assign hist_valid = (fill_cur == FILL_W'(HIST_LEN)) || (FILL_W'(rd_addr_reg) < fill_cur);
    assign hist_op    = hvld_q_reg ? $signed(hist_q_reg) : '0;

    // wet rounding and mix operands
    assign wet_tmp = acc_reg + (ACC_W'(1) << 21) - ACC_W'(acc_reg[ACC_W-1]);
    assign wet_sh  = wet_tmp >>> 22;
    assign dry_op  = PDRY_W'(dry_reg);
    assign inv_op  = $signed(PDRY_W'(fcr_pkg::Q16_ONE - cfg.mix_level));
    assign wet_op  = PWET_W'(wet_reg);
    assign mix_op  = $signed(PWET_W'(cfg.mix_level));
    assign sum_a   = SUM_W'(pdry_reg);
    assign sum_b   = SUM_W'(pwet_reg);
    assign rnd_tmp = sum_reg + SUM_W'(32768) - SUM_W'(sum_reg[SUM_W-1]);
    assign rnd     = rnd_tmp >>> 16;

    always_comb begin
        out_next.channel_out = ch;
        out_next.clipped     = 1'b0;
        if (cfg.tap_count == '0) begin
            out_next.sample_out = item_reg.sample_in;
        end else if (rnd > RES_MAX) begin
            out_next.sample_out = fcr_pkg::SAMPLE_MAX;
            out_next.clipped    = 1'b1;
        end else if (rnd < RES_MIN) begin
            out_next.sample_out = fcr_pkg::SAMPLE_MIN;
            out_next.clipped    = 1'b1;
        end else begin
            out_next.sample_out = SW'(rnd);
        end
    end

    assign status.taps_zero  = cfg.tap_count == '0;
    assign status.mac_last   = 32'(k_reg) + 32'd1 == 32'(cfg.tap_count);
    assign status.pipe_empty = !s1_v_reg && !s2_v_reg;
    assign status.out_busy   = out_valid_reg && !m_ready;
    assign m_valid           = out_valid_reg;
    assign m_data            = out_data_reg;

    // tap memory
    always_ff @(posedge aclk) begin
        if (tap_wr) tap_mem[TAP_AW'(s_data.tap_index)] <= s_data.tap_value;
        if (cmd.mac_issue) tap_q_reg <= tap_mem[k_reg];
    end

    // history memory
    always_ff @(posedge aclk) begin
        if (cmd.hist_write) hist_mem[ch][pos_cur] <= dry_val;
        if (cmd.mac_issue) hist_q_reg <= hist_mem[ch][rd_addr_reg];
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) item_reg <= s_data;
        if (cmd.scale) scl_prod_reg <= scl_a * scl_b;
        if (cmd.hist_write) begin
            dry_reg     <= dry_val;
            rd_addr_reg <= HA_W'(start_ext);
            k_reg       <= '0;
        end
        if (cmd.mac_issue) begin
            rd_addr_reg <= (rd_addr_reg == '0) ? HA_W'(HIST_LEN - 1) : rd_addr_reg - 1'b1;
            k_reg       <= k_reg + 1'b1;
            hvld_q_reg  <= hist_valid;
        end
        if (s1_v_reg) prod_reg <= PROD_W'(hist_op) * PROD_W'($signed(tap_q_reg));
        if (cmd.hist_write) begin
            acc_reg <= '0;
        end else if (s2_v_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.wet) wet_reg <= WET_W'(wet_sh);
        if (cmd.mix1) begin
            pdry_reg <= dry_op * inv_op;
            pwet_reg <= wet_op * mix_op;
        end
        if (cmd.mix2) sum_reg <= sum_a + sum_b;
        if (cmd.out_load) out_data_reg <= out_next;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '{default: '0};
            fill_reg      <= '{default: '0};
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.hist_write) begin
                pos_reg[ch] <= pos_nxt;
                if (fill_cur != FILL_W'(HIST_LEN)) fill_reg[ch] <= fill_cur + 1'b1;
            end
            s1_v_reg <= cmd.mac_issue;
            s2_v_reg <= s1_v_reg;
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: hw/rtl/fcr_checker.sv
// Port-level checks of the reverb and their binding to the top level.
`include "assert_macros.svh"

module fcr_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input fcr_pkg::fcr_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input fcr_pkg::fcr_out_t m_data
);

    logic out_stall, in_sample, in_tap, clip_beat, at_rail;

    assign out_stall = m_valid && !m_ready;
    assign in_sample = s_valid && s_ready && s_data.opcode == fcr_pkg::OP_SAMPLE;
    assign in_tap    = s_valid && s_ready && s_data.opcode == fcr_pkg::OP_TAP;
    assign clip_beat = m_valid && m_data.clipped;
    assign at_rail   = m_data.sample_out == fcr_pkg::SAMPLE_MAX
                       || m_data.sample_out == fcr_pkg::SAMPLE_MIN;

    // a stalled result beat holds
    `FCR_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_valid && $stable(m_data))

    // a sample beat occupies the block
    `FCR_ASSERT_NEXT(a_sample_busy, aclk, aresetn, in_sample, !s_ready)

    // a tap load leaves the input open
    `FCR_ASSERT_NEXT(a_tap_open, aclk, aresetn, in_tap, s_ready)

    // a clipped result sits at a rail
    `FCR_ASSERT_SAME(a_clip_rail, aclk, aresetn, clip_beat, at_rail)

endmodule

bind fir_convolution_reverb fcr_checker u_fcr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
